// ===== sv/ambient_light_lux_autorange_top_defines.svh =====
// Assertion macros used by the checker file alar_chk.sv.
`ifndef AMBIENT_LIGHT_LUX_AUTORANGE_TOP_DEFINES_SVH
`define AMBIENT_LIGHT_LUX_AUTORANGE_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ALAR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ALAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/alar_pkg.sv =====
package alar_pkg;

    // Field and datapath widths
    localparam int RAW_W      = 16;
    localparam int LUX_W      = 40;
    localparam int GAIN_W     = 2;
    localparam int ITIME_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int SHIFT_W    = 4;
    localparam int P_W        = 31;              // raw*36 << 9 stays below 2^31
    localparam int X_W        = 33;              // Q16 uncorrected lux
    localparam int OPA_W      = 50;              // wide multiplier operand
    localparam int HALF_W     = 25;              // one half of the wide operand
    localparam int PP_W       = HALF_W + X_W;    // partial product
    localparam int ACC_W      = OPA_W + X_W;     // full product

    // Product shift amounts
    localparam int RECIP_SH = 42;
    localparam int C4_SH    = 16;
    localparam int MID_SH   = 32;
    localparam int LUX_SH   = 48;
    localparam int A_W      = 49;                // C4*X >> 16 stays below 2^49
    localparam int Q_W      = ACC_W - MID_SH;
    localparam int L_W      = ACC_W - LUX_SH;

    // Gain codes
    localparam logic [GAIN_W-1:0] GAIN_X1 = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_X2 = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_D8 = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_D4 = 2'd3;

    // Integration time codes
    localparam logic [ITIME_W-1:0] ITIME_100MS = 3'd2;
    localparam logic [ITIME_W-1:0] ITIME_800MS = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ITIME = 2'd1;

    // Range thresholds on raw*36<<m (value times 10000)
    localparam logic [P_W-1:0] TH_LOW     = 31'd18800000;
    localparam logic [P_W-1:0] TH_MID_TOP = 31'd37710000;
    localparam logic [P_W-1:0] TH_HIGH    = 31'd37700000;

    // Reciprocal of 625 scaled by 2^54, rounded up: X = P*RECIP_M >> 42
    localparam logic [OPA_W-1:0] RECIP_M = 50'd28823037615172;

    // Correction polynomial coefficients
    localparam logic [OPA_W-1:0] COEF_C4 = 50'd2839795084;
    localparam logic [OPA_W-1:0] COEF_C3 = 50'd44354354953705;
    localparam logic [OPA_W-1:0] COEF_C2 = 50'd5871829222963;
    localparam logic [OPA_W-1:0] COEF_C1 = 50'd1102040504520;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic range_upd;
        logic mul_lo;
        logic mul_hi;
        logic post;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic first_step;
        logic last_step;
    } t_sts;

    // Scale exponent of a gain code
    function automatic logic [SHIFT_W-1:0] gain_shift(input logic [GAIN_W-1:0] gain);
        logic [SHIFT_W-1:0] sh;
        unique case (gain)
            GAIN_X1: sh = 4'd1;
            GAIN_X2: sh = 4'd0;
            GAIN_D8: sh = 4'd4;
            GAIN_D4: sh = 4'd3;
            default: sh = 4'd0;
        endcase
        return sh;
    endfunction

    // Scale exponent of an integration time code; unused codes scale like 25 ms
    function automatic logic [SHIFT_W-1:0] itime_shift(input logic [ITIME_W-1:0] itime);
        logic [SHIFT_W-1:0] sh;
        if (itime > ITIME_800MS) begin
            sh = 4'd5;
        end else begin
            sh = 4'd5 - {1'b0, itime};
        end
        return sh;
    endfunction

endpackage

// ===== sv/alar_ctrl.sv =====
module alar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output alar_pkg::t_cmd o_cmd,
    input  alar_pkg::t_sts i_sts
);
    import alar_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_POST
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Sequence one transaction: load, then five multiply and post steps
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo    = 1'b1;
                o_cmd.range_upd = i_sts.first_step;
                n_state         = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_POST;
            end
            S_POST: begin
                if (i_sts.last_step) begin
                    if (out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.post = 1'b1;
                    n_state    = S_MUL_LO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Set output valid on load, drop it when the receiver takes the result
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/alar_dp.sv =====
module alar_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  alar_pkg::t_cmd                      i_cmd,
    output alar_pkg::t_sts                      o_sts,
    input  logic [alar_pkg::RAW_W-1:0]          i_raw_counts,
    input  logic                                i_cfg_valid,
    input  logic [alar_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [alar_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [alar_pkg::LUX_W-1:0]          o_lux_q8,
    output logic [alar_pkg::GAIN_W-1:0]         o_gain_now,
    output logic [alar_pkg::ITIME_W-1:0]        o_itime_now,
    output logic                                o_range_switched
);
    import alar_pkg::*;

    typedef enum logic [2:0] {
        STEP_RECIP,
        STEP_C4,
        STEP_C3,
        STEP_C2,
        STEP_C1
    } t_step;

    // Range state
    logic [GAIN_W-1:0]  r_gain,  n_gain;
    logic [ITIME_W-1:0] r_itime, n_itime;
    logic               r_may_x1, n_may_x1;
    logic               r_may_x2, n_may_x2;
    logic               r_may_d8, n_may_d8;
    logic               r_sw,     n_sw;
    t_step              r_step,   n_step;

    // Arithmetic registers
    logic [OPA_W-1:0] r_opa, n_opa;
    logic [X_W-1:0]   r_opb, n_opb;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_neg, n_neg;

    // Output payload
    logic [LUX_W-1:0]   r_lux;
    logic [GAIN_W-1:0]  r_gain_out;
    logic [ITIME_W-1:0] r_itime_out;
    logic               r_sw_out;

    logic [P_W-1:0]     raw_ext;
    logic [P_W-1:0]     raw36;
    logic [SHIFT_W-1:0] shift;
    logic [P_W-1:0]     p_new;
    logic [P_W-1:0]     p_cur;
    logic               in_mid;
    logic               in_high;
    logic [HALF_W-1:0]  pp_a;
    logic [PP_W-1:0]    pp;
    logic [X_W-1:0]     x_val;
    logic [A_W-1:0]     a_val;
    logic [OPA_W-1:0]   a_ext;
    logic [Q_W-1:0]     q_val;
    logic [Q_W:0]       q_ext;
    logic [Q_W:0]       c2_ext;
    logic [Q_W:0]       c1_ext;
    logic [Q_W:0]       t2_pos;
    logic [Q_W:0]       t2_neg;
    logic [Q_W:0]       t1_sum;
    logic [L_W-1:0]     lux_val;

    assign o_sts.first_step = (r_step == STEP_RECIP);
    assign o_sts.last_step  = (r_step == STEP_C1);

    // Scale the raw count: raw*36 shifted by the gain and time exponents
    assign raw_ext = {{(P_W-RAW_W){1'b0}}, i_raw_counts};
    assign raw36   = (raw_ext << 5) + (raw_ext << 2);
    assign shift   = gain_shift(r_gain) + itime_shift(r_itime);
    assign p_new   = raw36 << shift;

    // Threshold compares on the scaled count held in operand B
    assign p_cur   = r_opb[P_W-1:0];
    assign in_mid  = (p_cur > TH_LOW) && (p_cur < TH_MID_TOP);
    assign in_high = (p_cur > TH_HIGH);

    // Shared multiplier: the low half of operand A on mul_lo, the high half on mul_hi
    assign pp_a = i_cmd.mul_hi ? r_opa[OPA_W-1:HALF_W] : r_opa[HALF_W-1:0];
    assign pp   = {{X_W{1'b0}}, pp_a} * {{HALF_W{1'b0}}, r_opb};

    // Product slices for each step
    assign x_val   = r_acc[RECIP_SH+X_W-1:RECIP_SH];
    assign a_val   = r_acc[C4_SH+A_W-1:C4_SH];
    assign a_ext   = {{(OPA_W-A_W){1'b0}}, a_val};
    assign q_val   = r_acc[ACC_W-1:MID_SH];
    assign q_ext   = {1'b0, q_val};
    assign c2_ext  = {{(Q_W+1-OPA_W){1'b0}}, COEF_C2};
    assign c1_ext  = {{(Q_W+1-OPA_W){1'b0}}, COEF_C1};
    assign t2_pos  = q_ext + c2_ext;
    assign t2_neg  = c2_ext - q_ext;
    assign t1_sum  = q_ext + c1_ext;
    assign lux_val = r_acc[ACC_W-1:LUX_SH];

    // Update range state from the switch rules, or take a register write
    always_comb begin
        n_gain   = r_gain;
        n_itime  = r_itime;
        n_may_x1 = r_may_x1;
        n_may_x2 = r_may_x2;
        n_may_d8 = r_may_d8;
        n_sw     = r_sw;
        if (i_cmd.range_upd) begin
            n_sw = 1'b0;
            if (in_mid) begin
                if (r_may_x1) begin
                    n_gain   = GAIN_X1;
                    n_may_x1 = 1'b0;
                    n_may_x2 = 1'b1;
                    n_may_d8 = 1'b1;
                    n_sw     = 1'b1;
                end
            end else if (in_high) begin
                if (r_may_d8) begin
                    n_gain   = GAIN_D8;
                    n_may_x1 = 1'b1;
                    n_may_x2 = 1'b1;
                    n_may_d8 = 1'b0;
                    n_sw     = 1'b1;
                end
            end else begin
                if (r_may_x2) begin
                    n_gain   = GAIN_X2;
                    n_may_x1 = 1'b1;
                    n_may_x2 = 1'b0;
                    n_may_d8 = 1'b1;
                    n_sw     = 1'b1;
                end
            end
            if (n_sw) begin
                n_itime = ITIME_100MS;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_GAIN:  n_gain  = i_cfg_data[GAIN_W-1:0];
                REG_START_ITIME: n_itime = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Restart the step on load, advance it on each post
    always_comb begin
        n_step = r_step;
        if (i_cmd.load) begin
            n_step = STEP_RECIP;
        end else if (i_cmd.post) begin
            unique case (r_step)
                STEP_RECIP: n_step = STEP_C4;
                STEP_C4:    n_step = STEP_C3;
                STEP_C3:    n_step = STEP_C2;
                STEP_C2:    n_step = STEP_C1;
                default:    n_step = STEP_RECIP;
            endcase
        end
    end

    // Load operands, multiply in halves, then form the next operand
    always_comb begin
        n_opa = r_opa;
        n_opb = r_opb;
        n_acc = r_acc;
        n_neg = r_neg;
        if (i_cmd.load) begin
            n_opa = RECIP_M;
            n_opb = {{(X_W-P_W){1'b0}}, p_new};
        end else if (i_cmd.mul_lo) begin
            n_acc = {{(ACC_W-PP_W){1'b0}}, pp};
        end else if (i_cmd.mul_hi) begin
            n_acc = r_acc + {pp, {HALF_W{1'b0}}};
        end else if (i_cmd.post) begin
            unique case (r_step)
                STEP_RECIP: begin
                    n_opb = x_val;
                    n_opa = COEF_C4;
                end
                STEP_C4: begin
                    if (a_ext >= COEF_C3) begin
                        n_opa = a_ext - COEF_C3;
                        n_neg = 1'b0;
                    end else begin
                        n_opa = COEF_C3 - a_ext;
                        n_neg = 1'b1;
                    end
                end
                STEP_C3: begin
                    if (!r_neg) begin
                        n_opa = t2_pos[OPA_W-1:0];
                    end else if (q_ext > c2_ext) begin
                        n_opa = '0;
                    end else begin
                        n_opa = t2_neg[OPA_W-1:0];
                    end
                end
                STEP_C2: n_opa = t1_sum[OPA_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and range state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_X2;
            r_itime  <= ITIME_100MS;
            r_may_x1 <= 1'b0;
            r_may_x2 <= 1'b1;
            r_may_d8 <= 1'b0;
            r_sw     <= 1'b0;
            r_step   <= STEP_RECIP;
        end else begin
            r_gain   <= n_gain;
            r_itime  <= n_itime;
            r_may_x1 <= n_may_x1;
            r_may_x2 <= n_may_x2;
            r_may_d8 <= n_may_d8;
            r_sw     <= n_sw;
            r_step   <= n_step;
        end
    end

    // Arithmetic payload
    always_ff @(posedge i_clk) begin
        r_opa <= n_opa;
        r_opb <= n_opb;
        r_acc <= n_acc;
        r_neg <= n_neg;
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_lux       <= {{(LUX_W-L_W){1'b0}}, lux_val};
            r_gain_out  <= r_gain;
            r_itime_out <= r_itime;
            r_sw_out    <= r_sw;
        end
    end

    assign o_lux_q8         = r_lux;
    assign o_gain_now       = r_gain_out;
    assign o_itime_now      = r_itime_out;
    assign o_range_switched = r_sw_out;

endmodule

// ===== sv/ambient_light_lux_autorange_top.sv =====
// Raw light count to corrected lux, with gain and integration-time tracking.
// Input channel: i_in_valid / o_in_ready carry one 16-bit raw count.
// Output channel: o_out_valid / i_out_ready carry lux (Q8, 40 bits), the gain
// and time codes in use after the transaction, and the range switch flag.
// Configuration: i_cfg_valid / o_cfg_ready write index 0 (gain) or 1 (time);
// other indexes are ignored. o_cfg_ready is always high; write only when idle.
// One 25x33 multiplier is shared over five products (reciprocal division by
// 625, then four Horner steps), each a low-half and a high-half multiply step
// and a step that forms the next operand or, after the last, loads the result;
// no new count is taken before that. The lux of a transaction uses the gain
// and time from before any switch it causes. Reset sets gain x2, 100 ms,
// clears the output valid and the internal switch flag, and enables only the
// switch to x2. A stalled receiver holds the result in the output register;
// then the block waits at the last step; no new input until the register frees.
module ambient_light_lux_autorange_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_raw_counts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [39:0] o_lux_q8,
    output logic [1:0]  o_gain_now,
    output logic [2:0]  o_itime_now,
    output logic        o_range_switched,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data
);
    import alar_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    alar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Scaling, range tracking and polynomial datapath
    alar_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_raw_counts     (i_raw_counts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_lux_q8         (o_lux_q8),
        .o_gain_now       (o_gain_now),
        .o_itime_now      (o_itime_now),
        .o_range_switched (o_range_switched)
    );

endmodule

// ===== sv/alar_chk.sv =====
`include "ambient_light_lux_autorange_top_defines.svh"

module alar_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [39:0] o_lux_q8,
    input logic [1:0]  o_gain_now,
    input logic [2:0]  o_itime_now,
    input logic        o_range_switched
);
    import alar_pkg::*;

    // Stalled result stays put
    `ALAR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_lux_q8) && $stable(o_gain_now),
        "result changed while stalled")

    // A range switch always returns to 100 ms
    `ALAR_ASSERT_SAME(a_switch_itime, o_out_valid && o_range_switched,
        o_itime_now == ITIME_100MS, "switch without 100 ms")

    // A range switch never lands on gain d4
    `ALAR_ASSERT_SAME(a_switch_gain, o_out_valid && o_range_switched,
        o_gain_now != GAIN_D4, "switch to gain d4")

    // One transaction in flight at a time
    `ALAR_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready,
        "input ready while busy")

endmodule

bind ambient_light_lux_autorange_top alar_chk u_alar_chk (.*);

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import alar_pkg::*;

    // Run shape
    localparam int unsigned RANDOM_ITEMS     = 750;
    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned DRAIN_CYCLES     = 24;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned PRESSURE_ITEMS   = 20;
    localparam longint      TIMEOUT_NS       = 5_000_000;

    // Register indexes outside the register map
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Range thresholds, as value times 10000
    localparam logic [63:0] LOW_EDGE_P = 64'd18800000;
    localparam logic [63:0] MID_TOP_P  = 64'd37710000;
    localparam logic [63:0] HIGH_P     = 64'd37700000;

    // Correction polynomial coefficients (C4, C3 in Q72, C2 in Q56, C1 in Q40)
    localparam logic [63:0] K_C4    = 64'd2839795084;
    localparam logic [63:0] K_C3    = 64'd44354354953705;
    localparam logic [63:0] K_C2    = 64'd5871829222963;
    localparam logic [63:0] K_C1    = 64'd1102040504520;
    localparam logic [63:0] LUX_SAT = (64'd1 << 40) - 64'd1;

    typedef struct packed {
        logic [LUX_W-1:0]   lux;
        logic [GAIN_W-1:0]  gain;
        logic [ITIME_W-1:0] itime;
        logic               switched;
    } t_lux_result;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [RAW_W-1:0]      i_raw_counts;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [LUX_W-1:0]      o_lux_q8;
    logic [GAIN_W-1:0]     o_gain_now;
    logic [ITIME_W-1:0]    o_itime_now;
    logic                  o_range_switched;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predicted converter state
    logic [GAIN_W-1:0]  gain_state;
    logic [ITIME_W-1:0] itime_state;
    logic               can_go_x1;
    logic               can_go_x2;
    logic               can_go_d8;

    t_lux_result lux_due_q[$];
    int unsigned error_count = 0;
    logic        long_hold;

    ambient_light_lux_autorange_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_raw_counts     (i_raw_counts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_lux_q8         (o_lux_q8),
        .o_gain_now       (o_gain_now),
        .o_itime_now      (o_itime_now),
        .o_range_switched (o_range_switched),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // (a*b) >> s, saturating at 64 bits
    function automatic logic [63:0] mul_shift_sat(input logic [63:0] a, input logic [63:0] b,
                                                  input int unsigned s);
        logic [127:0] full;
        full = ({64'd0, a} * {64'd0, b}) >> s;
        if (full[127:64] != 64'd0) begin
            return '1;
        end
        return full[63:0];
    endfunction

    // Horner evaluation of the correction polynomial on Q16 uncorrected lux
    function automatic logic [63:0] corrected_lux(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] t2;
        logic [63:0] t1;
        logic [63:0] neg;
        logic [63:0] lux;
        a = mul_shift_sat(K_C4, x, 16);
        if (a >= K_C3) begin
            t2 = K_C2 + mul_shift_sat(a - K_C3, x, 32);
        end else begin
            // clamp a negative second term at zero
            neg = mul_shift_sat(K_C3 - a, x, 32);
            t2  = (neg > K_C2) ? 64'd0 : K_C2 - neg;
        end
        t1  = mul_shift_sat(t2, x, 32) + K_C1;
        lux = mul_shift_sat(t1, x, 48);
        return (lux > LUX_SAT) ? LUX_SAT : lux;
    endfunction

    // Binary scale exponent of the gain and time in use; unused time codes act as 25 ms
    function automatic logic [3:0] scale_exp();
        logic [3:0] g;
        case (gain_state)
            GAIN_X1: g = 4'd1;
            GAIN_X2: g = 4'd0;
            GAIN_D8: g = 4'd4;
            default: g = 4'd3;
        endcase
        if (itime_state <= ITIME_800MS) begin
            return g + 4'(ITIME_800MS - itime_state);
        end
        return g + 4'd5;
    endfunction

    // Convert one count, then advance the range tracking
    function automatic t_lux_result convert_count(input logic [RAW_W-1:0] raw);
        logic [63:0] p;
        logic [63:0] x;
        logic [63:0] lux;
        logic        sw;
        t_lux_result r;
        p   = (64'(raw) * 64'd36) << scale_exp();
        x   = (p << 16) / 64'd10000;
        lux = corrected_lux(x);
        sw  = 1'b0;
        if (p > LOW_EDGE_P && p < MID_TOP_P) begin
            if (can_go_x1) begin
                gain_state = GAIN_X1;
                {can_go_x1, can_go_x2, can_go_d8} = 3'b011;
                sw = 1'b1;
            end
        end else if (p > HIGH_P) begin
            if (can_go_d8) begin
                gain_state = GAIN_D8;
                {can_go_x1, can_go_x2, can_go_d8} = 3'b110;
                sw = 1'b1;
            end
        end else begin
            if (can_go_x2) begin
                gain_state = GAIN_X2;
                {can_go_x1, can_go_x2, can_go_d8} = 3'b101;
                sw = 1'b1;
            end
        end
        if (sw) begin
            itime_state = ITIME_100MS;
        end
        r.lux      = lux[LUX_W-1:0];
        r.gain     = gain_state;
        r.itime    = itime_state;
        r.switched = sw;
        return r;
    endfunction

    // Load a register write; flags are left alone
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_START_GAIN:  gain_state = data[GAIN_W-1:0];
            REG_START_ITIME: itime_state = data;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Compare one output transaction with the oldest pending result
    task automatic check_result();
        t_lux_result want;
        if (lux_due_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, lux %0d", o_lux_q8));
            return;
        end
        want = lux_due_q.pop_front();
        if (o_lux_q8 !== want.lux)
            report_mismatch($sformatf("lux expected %0d got %0d", want.lux, o_lux_q8));
        if (o_gain_now !== want.gain)
            report_mismatch($sformatf("gain expected %0d got %0d", want.gain, o_gain_now));
        if (o_itime_now !== want.itime)
            report_mismatch($sformatf("itime expected %0d got %0d", want.itime, o_itime_now));
        if (o_range_switched !== want.switched)
            report_mismatch($sformatf("switch expected %0d got %0d", want.switched,
                                      o_range_switched));
    endtask

    // Track register writes, check results, predict accepted counts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
            end
            if (o_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && o_in_ready) begin
                lux_due_q.push_back(convert_count(i_raw_counts));
            end
        end
    end

    // Drive output ready: changing stall patterns, plus a long hold on request
    initial begin : out_ready_pattern
        t_rx_mode    mode;
        int unsigned left;
        int unsigned tick;
        i_out_ready = 1'b0;
        mode = RX_STEADY;
        left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 2));
                    left = $urandom_range(20, 150);
                end
                left--;
                tick++;
                case (mode)
                    RX_STEADY: i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    default:   i_out_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    // Offer one count and hold it until accepted; call at a falling edge
    task automatic send_count(input logic [RAW_W-1:0] raw);
        i_raw_counts <= raw;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Drop input valid for the span given by n; zero keeps a burst going
    task automatic idle_input(input int unsigned n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Wait until every pending result has come out
    task automatic settle_outputs();
        idle_input(1);
        while (lux_due_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write transaction; block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Pick a count, biased toward the range edges of the current scale
    function automatic logic [RAW_W-1:0] pick_count();
        logic [31:0] step;
        logic [31:0] bound;
        step = 32'd36 << scale_exp();
        case ($urandom_range(0, 9))
            0, 1:    bound = LOW_EDGE_P[31:0] / step;
            2, 3:    bound = HIGH_P[31:0] / step;
            4:       bound = MID_TOP_P[31:0] / step;
            5:       return 16'($urandom_range(0, 255));
            6:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF - 16'($urandom_range(0, 15))
                                                        : 16'd1 << $urandom_range(0, 15);
            default: return 16'($urandom());
        endcase
        bound = bound + $urandom_range(0, 4) - 2;
        if (bound > 32'd65535) begin
            return 16'hFFFF - 16'($urandom_range(0, 63));
        end
        return bound[15:0];
    endfunction

    // Reset settings, range walk low -> x2, mid -> x1, high -> d8, bit patterns
    task automatic test_reset_state();
        send_count(16'd65535);
        send_count(16'd0);
        idle_input(2);
        send_count(16'd65535);
        send_count(16'd65535);
        idle_input(1);
        send_count(16'h5555);
        send_count(16'hAAAA);
        send_count(16'd1);
    endtask

    // Every gain code, every time code including the unused ones
    task automatic test_register_sweep();
        for (int i = 0; i < 8; i++) begin
            settle_outputs();
            write_reg(REG_START_GAIN, 3'(i));
            write_reg(REG_START_ITIME, 3'(7 - i));
            send_count(16'hFFFF);
            idle_input($urandom_range(0, 3));
            send_count(16'($urandom()));
        end
    endtask

    // Writes outside the register map must change nothing
    task automatic test_ignored_index();
        settle_outputs();
        write_reg(REG_SPARE_2, 3'b111);
        write_reg(REG_SPARE_3, 3'b111);
        send_count(16'd40000);
    endtask

    // Hold the output for a long stretch while counts keep coming
    task automatic test_backpressure();
        settle_outputs();
        long_hold = 1'b1;
        for (int k = 0; k < PRESSURE_ITEMS; k++) begin
            send_count(pick_count());
        end
        idle_input(1);
        wait (!long_hold);
        settle_outputs();
    endtask

    // Bursts of random counts with reconfiguration between phases
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned next_cfg;
        int unsigned burst;
        sent     = 0;
        next_cfg = $urandom_range(40, 90);
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                send_count(pick_count());
                sent++;
            end
            idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
            if (sent >= next_cfg) begin
                settle_outputs();
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_START_GAIN, 3'($urandom()));
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_START_ITIME, 3'($urandom_range(0, 7)));
                if ($urandom_range(0, 5) == 0)
                    write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_2 : REG_SPARE_3,
                              3'($urandom()));
                next_cfg = sent + $urandom_range(40, 90);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_raw_counts = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        long_hold    = 1'b0;
        gain_state   = GAIN_X2;
        itime_state  = ITIME_100MS;
        can_go_x1    = 1'b0;
        can_go_x2    = 1'b1;
        can_go_d8    = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_register_sweep();
        test_ignored_index();
        test_backpressure();
        test_random_traffic();

        settle_outputs();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("testbench: errors");
        $finish;
    end

endmodule
